FILE: hw/rtl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_MAX     = 4;
    localparam int RCNT_W      = $clog2(RES_MAX + 1);
    localparam int RIDX_W      = $clog2(RES_MAX);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_start;
    } jsu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } jsu_out_t;

    typedef struct packed {
        logic [RES_MAX-1:0][7:0] data;
        logic [RCNT_W-1:0]       cnt;
    } jsu_res_t;

    typedef struct packed {
        logic     vld;
        jsu_res_t res;
    } jsu_push_t;

endpackage
`default_nettype wire

FILE: hw/rtl/json_string_unescape_utf8_unit.sv
// JSON string unescaper: takes one escaped string byte per item and delivers
// the decoded bytes one per cycle, with \uXXXX escapes (surrogate pairs joined)
// written as UTF-8 and run_last marking the final byte of each input item.
// An input item is taken every cycle while the four-entry result queue has
// room; each item is decoded combinationally from the input register, and a
// byte that yields output writes its bytes as one queue entry that feeds the
// result channel. Throughput is one output byte per cycle while dec_stall is
// low: a multi-byte unicode escape drains from its entry byte by byte and
// the input stalls only once the queue holds four pending items.
`default_nettype none
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     esc_valid,
    output logic          esc_stall,
    input  wire jsu_in_t  esc_item,
    output logic          dec_valid,
    input  wire logic     dec_stall,
    output jsu_out_t      dec_item
);

    jsu_push_t push;
    logic      room;

    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .esc_valid (esc_valid),
        .esc_stall (esc_stall),
        .esc_item  (esc_item),
        .room      (room),
        .push      (push)
    );

    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_item  (dec_item)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/jsu_decode.sv
`default_nettype none
module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      esc_valid,
    output logic           esc_stall,
    input  wire jsu_in_t   esc_item,
    input  wire logic      room,
    output jsu_push_t      push
);

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ESCAPE  = 3'd1;
    localparam logic [2:0] MODE_HEX_ONE = 3'd2;
    localparam logic [2:0] MODE_WAIT_BS = 3'd3;
    localparam logic [2:0] MODE_WAIT_U  = 3'd4;
    localparam logic [2:0] MODE_HEX_TWO = 3'd5;
    localparam logic [2:0] MODE_ENDED   = 3'd6;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    function automatic jsu_res_t one_byte(input logic [7:0] b);
        jsu_res_t r;
        r         = '0;
        r.data[0] = b;
        r.cnt     = RCNT_W'(1);
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] m;
        unique case (b)
            CH_B:    m = 8'h08;
            CH_F:    m = 8'h0C;
            CH_N:    m = 8'h0A;
            CH_R:    m = 8'h0D;
            CH_T:    m = 8'h09;
            default: m = b;
        endcase
        return m;
    endfunction

    function automatic jsu_res_t utf8(input logic [20:0] cp);
        jsu_res_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.data[0] = cp[7:0];
            r.cnt     = RCNT_W'(1);
        end else if (cp < 21'h800) begin
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
            r.cnt     = RCNT_W'(2);
        end else if (cp < 21'h10000) begin
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
            r.cnt     = RCNT_W'(3);
        end else begin
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
            r.cnt     = RCNT_W'(4);
        end
        return r;
    endfunction

    logic        in_vld_reg;
    jsu_in_t     in_reg;
    logic        fire;
    logic        accept;

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stop_reg, stop_next;
    logic [15:0] cu_reg, cu_next;
    logic [9:0]  hs_reg, hs_next;

    logic [7:0]  b;
    logic [3:0]  hx_val;
    logic        hx_is;
    logic [15:0] hx_cu;
    logic        hx_stop;
    logic        hx_done;
    logic [1:0]  hx_cnt;
    logic        lo_sur;
    logic        hi_sur;
    jsu_res_t    res;

    assign fire      = in_vld_reg & room;
    assign esc_stall = in_vld_reg & ~room;
    assign accept    = esc_valid & ~esc_stall;
    assign b         = in_reg.in_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= esc_item;
        end
    end

    always_comb
    begin
        hx_is  = 1'b1;
        hx_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            hx_val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            hx_val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            hx_val = 4'(b - 8'h37);
        end
        else
        begin
            hx_is = 1'b0;
        end
        hx_cu   = (!stop_reg && hx_is) ? {cu_reg[11:0], hx_val} : cu_reg;
        hx_stop = stop_reg | ~hx_is;
        hx_done = (cnt_reg == 2'd3);
        hx_cnt  = hx_done ? cnt_reg : cnt_reg + 2'd1;
        lo_sur  = (hx_cu >= 16'hDC00) && (hx_cu <= 16'hDFFF);
        hi_sur  = (hx_cu >= 16'hD800) && (hx_cu <= 16'hDBFF);
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        stop_next = stop_reg;
        cu_next   = cu_reg;
        hs_next   = hs_reg;
        res       = '0;
        if (in_reg.string_start)
        begin
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
            stop_next = 1'b0;
            cu_next   = 16'd0;
            hs_next   = 10'd0;
        end
        else if (mode_reg == MODE_ENDED)
        begin
            mode_next = MODE_ENDED;
        end
        else if (b == 8'd0)
        begin
            mode_next = MODE_ENDED;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESCAPE, MODE_WAIT_U:
                begin
                    if (b == CH_U)
                    begin
                        cnt_next  = 2'd0;
                        stop_next = 1'b0;
                        cu_next   = 16'd0;
                        mode_next = (mode_reg == MODE_ESCAPE) ? MODE_HEX_ONE : MODE_HEX_TWO;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        res       = one_byte(esc_map(b));
                    end
                end
                MODE_HEX_ONE:
                begin
                    cnt_next  = hx_cnt;
                    stop_next = hx_stop;
                    cu_next   = hx_cu;
                    if (hx_done)
                    begin
                        mode_next = MODE_NORMAL;
                        if (hx_cu == 16'd0 || lo_sur)
                        begin
                            res = '0;
                        end
                        else if (hi_sur)
                        begin
                            hs_next   = hx_cu[9:0];
                            mode_next = MODE_WAIT_BS;
                        end
                        else
                        begin
                            res = utf8({5'd0, hx_cu});
                        end
                    end
                end
                MODE_HEX_TWO:
                begin
                    cnt_next  = hx_cnt;
                    stop_next = hx_stop;
                    cu_next   = hx_cu;
                    if (hx_done)
                    begin
                        mode_next = MODE_NORMAL;
                        if (lo_sur)
                        begin
                            res = utf8(21'h10000 + {1'b0, hs_reg, hx_cu[9:0]});
                        end
                    end
                end
                MODE_WAIT_BS:
                begin
                    if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_WAIT_U;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        res       = one_byte(b);
                    end
                end
                default:
                begin
                    if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        mode_next = MODE_NORMAL;
                        res       = one_byte(b);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
            stop_reg <= 1'b0;
            cu_reg   <= 16'd0;
            hs_reg   <= 10'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            stop_reg <= stop_next;
            cu_reg   <= cu_next;
            hs_reg   <= hs_next;
        end
    end

    assign push.vld = fire & (res.cnt != '0);
    assign push.res = res;

`ifndef SYNTHESIS
    a_start_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reg.string_start |=> mode_reg == MODE_NORMAL && hs_reg == 10'd0)
        else $error("string start did not reset decode state");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push.vld |-> push.res.cnt <= RCNT_W'(RES_MAX))
        else $error("decoded item longer than four bytes");
    a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_reg == MODE_ENDED && !in_reg.string_start |-> !push.vld)
        else $error("output after end of string");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/jsu_queue.sv
`default_nettype none
module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire jsu_push_t push,
    output logic           room,
    output logic           dec_valid,
    input  wire logic      dec_stall,
    output jsu_out_t       dec_item
);

    jsu_res_t            q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg;
    logic [QPTR_W-1:0]   tail_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [RIDX_W-1:0]   idx_reg;
    jsu_res_t            head_ent;
    logic                last_byte;
    logic                pop_byte;
    logic                pop_ent;

    assign head_ent  = q_mem[head_reg];
    assign last_byte = (RCNT_W'(idx_reg) + RCNT_W'(1)) == head_ent.cnt;
    assign dec_valid = (count_reg != '0);
    assign pop_byte  = dec_valid & ~dec_stall;
    assign pop_ent   = pop_byte & last_byte;
    assign room      = (count_reg != QCNT_W'(QUEUE_DEPTH));

    assign dec_item.out_byte = head_ent.data[idx_reg];
    assign dec_item.run_last = last_byte;

    always_ff @(posedge clk)
    begin
        if (push.vld)
        begin
            q_mem[tail_reg] <= push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (push.vld)
            begin
                tail_reg <= tail_reg + QPTR_W'(1);
            end
            if (pop_ent)
            begin
                head_reg <= head_reg + QPTR_W'(1);
                idx_reg  <= '0;
            end
            else if (pop_byte)
            begin
                idx_reg <= idx_reg + RIDX_W'(1);
            end
            if (push.vld && !pop_ent)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (!push.vld && pop_ent)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.vld |-> count_reg != QCNT_W'(QUEUE_DEPTH))
        else $error("item pushed into full queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ent |=> idx_reg == '0)
        else $error("byte index not cleared on item pop");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 160;
    localparam int HOLD_LEN    = 150;
    localparam int DIR_N       = 28;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_U   = 8'h75;

    typedef enum logic [2:0] {
        UNESC_COPY,
        UNESC_ESCAPE,
        UNESC_HEX1,
        UNESC_WAIT_BSL,
        UNESC_WAIT_U,
        UNESC_HEX2,
        UNESC_ENDED
    } unesc_state_e;

    typedef struct packed {
        logic        start;
        logic [7:0]  in_byte;
        logic        typed;
        logic [2:0]  n_typed;
        logic [31:0] typed_bytes;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIR_N] = '{
        '{1'b1, 8'h22, 1'b1, 3'd0, 32'h0},
        '{1'b0, 8'h41, 1'b1, 3'd1, 32'h41000000},
        '{1'b0, 8'hFF, 1'b1, 3'd1, 32'hFF000000},
        '{1'b0, 8'h01, 1'b1, 3'd1, 32'h01000000},
        '{1'b0, 8'h5C, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h6E, 1'b1, 3'd1, 32'h0A000000},
        '{1'b0, 8'h5C, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h74, 1'b1, 3'd1, 32'h09000000},
        '{1'b0, 8'h5C, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h75, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h32, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h30, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h41, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h63, 1'b1, 3'd3, 32'hE282AC00},
        '{1'b0, 8'h5C, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h75, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h44, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h38, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h33, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h44, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h5C, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h75, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h44, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h45, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h30, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h30, 1'b0, 3'd0, 32'h0},
        '{1'b0, 8'h00, 1'b1, 3'd0, 32'h0},
        '{1'b0, 8'h7A, 1'b1, 3'd0, 32'h0}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     esc_valid = 1'b0;
    logic     esc_stall;
    jsu_in_t  esc_item  = '0;
    logic     dec_valid;
    logic     dec_stall = 1'b0;
    jsu_out_t dec_item;

    json_string_unescape_utf8_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .esc_valid (esc_valid),
        .esc_stall (esc_stall),
        .esc_item  (esc_item),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_item  (dec_item)
    );

    always #4 clk = ~clk;

    unesc_state_e scan_state  = UNESC_COPY;
    logic [1:0]   hex_count   = '0;
    logic         hex_stopped = 1'b0;
    logic [15:0]  unit_acc    = '0;
    logic [9:0]   high_bits   = '0;
    logic [7:0]   step_bytes[$];

    jsu_out_t unescaped_q[$];
    int       mismatches     = 0;
    int       fed_items      = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    logic     hold_armed     = 1'b0;
    int       hold_cnt       = 0;
    int       cycle_cnt      = 0;

    task automatic add_step_byte(input logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_step_byte(cp[7:0]);
        end
        else if (cp < 21'h800) begin
            add_step_byte({3'b110, cp[10:6]});
            add_step_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000) begin
            add_step_byte({4'b1110, cp[15:12]});
            add_step_byte({2'b10, cp[11:6]});
            add_step_byte({2'b10, cp[5:0]});
        end
        else begin
            add_step_byte({5'b11110, cp[20:18]});
            add_step_byte({2'b10, cp[17:12]});
            add_step_byte({2'b10, cp[11:6]});
            add_step_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic clear_group();
        hex_count   = '0;
        hex_stopped = 1'b0;
        unit_acc    = '0;
    endtask

    task automatic take_hex(input logic [7:0] b, output logic group_done);
        logic [4:0] v;
        v = 5'd16;
        if (b >= "0" && b <= "9") v = 5'(b - 8'h30);
        else if (b >= "a" && b <= "f") v = 5'(b - 8'h61 + 8'd10);
        else if (b >= "A" && b <= "F") v = 5'(b - 8'h41 + 8'd10);
        if (!hex_stopped && v < 5'd16) unit_acc = {unit_acc[11:0], v[3:0]};
        else hex_stopped = 1'b1;
        group_done = (hex_count == 2'd3);
        if (!group_done) hex_count = hex_count + 2'd1;
    endtask

    task automatic do_escape(input logic [7:0] b);
        scan_state = UNESC_COPY;
        case (b)
            "b":     add_step_byte(8'h08);
            "f":     add_step_byte(8'h0C);
            "n":     add_step_byte(8'h0A);
            "r":     add_step_byte(8'h0D);
            "t":     add_step_byte(8'h09);
            CH_U:
            begin
                clear_group();
                scan_state = UNESC_HEX1;
            end
            default: add_step_byte(b);
        endcase
    endtask

    task automatic do_copy(input logic [7:0] b);
        if (b == CH_BSL) scan_state = UNESC_ESCAPE;
        else add_step_byte(b);
    endtask

    task automatic unescape_step(input jsu_in_t it);
        logic [7:0] b;
        logic       done;
        b = it.in_byte;
        step_bytes.delete();
        if (it.string_start) begin
            scan_state = UNESC_COPY;
            high_bits  = '0;
            clear_group();
        end
        else if (scan_state == UNESC_ENDED) begin
        end
        else if (b == 8'h00) begin
            scan_state = UNESC_ENDED;
        end
        else begin
            case (scan_state)
                UNESC_ESCAPE: do_escape(b);
                UNESC_HEX1:
                begin
                    take_hex(b, done);
                    if (done) begin
                        scan_state = UNESC_COPY;
                        if (unit_acc == 16'h0 || (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF)) begin
                        end
                        else if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF) begin
                            high_bits  = unit_acc[9:0];
                            scan_state = UNESC_WAIT_BSL;
                        end
                        else begin
                            emit_utf8({5'd0, unit_acc});
                        end
                    end
                end
                UNESC_WAIT_BSL:
                begin
                    if (b == CH_BSL) begin
                        scan_state = UNESC_WAIT_U;
                    end
                    else begin
                        scan_state = UNESC_COPY;
                        do_copy(b);
                    end
                end
                UNESC_WAIT_U:
                begin
                    if (b == CH_U) begin
                        clear_group();
                        scan_state = UNESC_HEX2;
                    end
                    else begin
                        do_escape(b);
                    end
                end
                UNESC_HEX2:
                begin
                    take_hex(b, done);
                    if (done) begin
                        scan_state = UNESC_COPY;
                        if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF)
                            emit_utf8(21'h10000 + {1'b0, high_bits, unit_acc[9:0]});
                    end
                end
                default:
                begin
                    scan_state = UNESC_COPY;
                    do_copy(b);
                end
            endcase
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        jsu_out_t e;
        e.out_byte = b;
        e.run_last = last;
        unescaped_q.insert(unescaped_q.size(), e);
    endtask

    task automatic send_item(input jsu_in_t it, input logic typed, input logic [2:0] n_typed,
                             input logic [31:0] typed_bytes);
        while ($urandom_range(99) < send_idle_pct) begin
            esc_valid <= 1'b0;
            @(posedge clk);
        end
        esc_valid <= 1'b1;
        esc_item  <= it;
        @(posedge clk);
        while (esc_stall) @(posedge clk);
        fed_items++;
        unescape_step(it);
        if (typed) begin
            for (int i = 0; i < n_typed; i++)
                queue_byte(typed_bytes[31 - 8*i -: 8], i == n_typed - 1);
        end
        else begin
            for (int i = 0; i < step_bytes.size(); i++)
                queue_byte(step_bytes[i], i == step_bytes.size() - 1);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic start);
        jsu_in_t it;
        it.in_byte      = b;
        it.string_start = start;
        send_item(it, 1'b0, 3'd0, 32'h0);
    endtask

    task automatic send_hex4(input logic [15:0] unit, input int stop_at);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int i = 0; i < 4; i++) begin
            nib = unit[15 - 4*i -: 4];
            if (nib < 4'd10) ch = 8'h30 + {4'd0, nib};
            else ch = ($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
            if (i == stop_at) begin
                ch = 8'($urandom_range(1, 255));
                while ((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
                       (ch >= "A" && ch <= "F"))
                    ch = 8'($urandom_range(1, 255));
            end
            send_byte(ch, 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_unit();
        logic [15:0] edges [8] = '{16'h0001, 16'h007F, 16'h0080, 16'h07FF,
                                   16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 16'h7F));
            2:       return 16'($urandom_range(16'h80, 16'h7FF));
            3:       return 16'($urandom_range(16'h800, 16'hD7FF));
            4:       return 16'($urandom_range(16'hE000, 16'hFFFF));
            5:       return 16'($urandom_range(16'hDC00, 16'hDFFF));
            6:       return edges[$urandom_range(7)];
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random_chunk();
        int          r;
        int          k;
        logic [7:0]  b;
        logic [15:0] hi;
        logic [7:0]  simple_esc [6] = '{"b", "f", "n", "r", "t", "/"};
        r = $urandom_range(99);
        if (r < 30) begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_BSL) b = "A";
            send_byte(b, 1'b0);
        end
        else if (r < 45) begin
            send_byte(CH_BSL, 1'b0);
            if ($urandom_range(2) != 0) begin
                send_byte(simple_esc[$urandom_range(5)], 1'b0);
            end
            else begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_U) b = CH_BSL;
                send_byte(b, 1'b0);
            end
        end
        else if (r < 70) begin
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_U, 1'b0);
            send_hex4(pick_unit(), ($urandom_range(9) == 0) ? $urandom_range(3) : 4);
        end
        else if (r < 86) begin
            case ($urandom_range(3))
                0:       hi = 16'hD800;
                1:       hi = 16'hDBFF;
                default: hi = 16'($urandom_range(16'hD800, 16'hDBFF));
            endcase
            send_byte(CH_BSL, 1'b0);
            send_byte(CH_U, 1'b0);
            send_hex4(hi, 4);
            k = $urandom_range(19);
            if (k < 16) begin
                send_byte(CH_BSL, 1'b0);
                send_byte(CH_U, 1'b0);
                if (k < 13) send_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)), 4);
                else send_hex4(pick_unit(), ($urandom_range(3) == 0) ? $urandom_range(3) : 4);
            end
            else if (k < 18) begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_BSL) b = "x";
                send_byte(b, 1'b0);
            end
            else begin
                send_byte(CH_BSL, 1'b0);
                send_byte(simple_esc[$urandom_range(5)], 1'b0);
            end
        end
        else if (r < 91) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (r < 94) begin
            send_byte(8'h00, 1'b0);
            repeat ($urandom_range(2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(15) == 0);
        end
    endtask

    task automatic wait_drained();
        esc_valid <= 1'b0;
        do @(posedge clk); while (unescaped_q.size() != 0);
    endtask

    always @(posedge clk) begin
        jsu_out_t e;
        if (rst_n && dec_valid && !dec_stall) begin
            if (unescaped_q.size() == 0) begin
                $display("%0t: unexpected item, out_byte %h run_last %b",
                         $time, dec_item.out_byte, dec_item.run_last);
                mismatches++;
            end
            else begin
                e = unescaped_q.pop_front();
                if (dec_item.out_byte !== e.out_byte) begin
                    $display("%0t: out_byte expected %h, got %h",
                             $time, e.out_byte, dec_item.out_byte);
                    mismatches++;
                end
                if (dec_item.run_last !== e.run_last) begin
                    $display("%0t: run_last expected %b, got %b",
                             $time, e.run_last, dec_item.run_last);
                    mismatches++;
                end
            end
        end
        if (hold_armed && hold_cnt < HOLD_LEN) begin
            dec_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end
        else begin
            if (!hold_armed) hold_cnt <= 0;
            dec_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("** json_string_unescape_utf8_unit: FAILED **");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_item('{in_byte: DIRECTED[i].in_byte, string_start: DIRECTED[i].start},
                      DIRECTED[i].typed, DIRECTED[i].n_typed, DIRECTED[i].typed_bytes);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  = 66;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 66;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct <= 12;
                end
            endcase
            while (fed_items < DIR_N + (ph + 1) * RAND_ITEMS / 4) send_random_chunk();
            wait_drained();
        end

        // hold the result side while items keep coming so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_armed     <= 1'b1;
        while (hold_cnt < HOLD_LEN) send_random_chunk();
        hold_armed <= 1'b0;
        repeat (10) send_random_chunk();
        wait_drained();

        repeat (16) @(posedge clk);
        if (mismatches == 0 && unescaped_q.size() == 0)
            $display("** json_string_unescape_utf8_unit: PASSED **");
        else
            $display("** json_string_unescape_utf8_unit: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
